// ===== sv/u8cy_pkg.sv =====
// Shared types, constants and code tables for the UTF-8 Cyrillic display code translator.
`timescale 1ns / 1ps

package u8cy_pkg;

   localparam logic [7:0] LEAD_D0      = 8'hD0;
   localparam logic [7:0] LEAD_D1      = 8'hD1;
   localparam logic [7:0] D0_TAB_LO    = 8'h90;
   localparam logic [7:0] D0_TAB_HI    = 8'hBF;
   localparam logic [7:0] D1_TAB_LO    = 8'h80;
   localparam logic [7:0] D1_TAB_HI    = 8'h8F;
   localparam logic [7:0] D0_IO_TRAIL  = 8'h81;
   localparam logic [7:0] D1_IO_TRAIL  = 8'h91;
   localparam logic [7:0] CODE_IO_UP   = 8'hCB;
   localparam logic [7:0] CODE_IO_LOW  = 8'hEB;

   // Output queue geometry.
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } disp_word_type;

   typedef struct packed {
      logic [1:0]    word_cnt;      // words produced by this byte: 0, 1 or 2
      disp_word_type word0;         // first word in stream order
      disp_word_type word1;         // second word, only when word_cnt is 2
      logic          lead_held_nxt;
      logic          lead_is_d1_nxt;
   } decode_type;

   // Table for lead 0xD0, trail bytes 0x90..0xBF.
   function automatic logic [7:0] tab_d0(input logic [5:0] idx);
      logic [7:0] code;
      case (idx)
         6'd0:  code = 8'h41;  6'd1:  code = 8'h08;  6'd2:  code = 8'h42;  6'd3:  code = 8'h09;
         6'd4:  code = 8'h0a;  6'd5:  code = 8'h45;  6'd6:  code = 8'h0b;  6'd7:  code = 8'h0c;
         6'd8:  code = 8'h0d;  6'd9:  code = 8'h0e;  6'd10: code = 8'h4b;  6'd11: code = 8'h0f;
         6'd12: code = 8'h4d;  6'd13: code = 8'h48;  6'd14: code = 8'h4f;  6'd15: code = 8'h10;
         6'd16: code = 8'h50;  6'd17: code = 8'h43;  6'd18: code = 8'h54;  6'd19: code = 8'h11;
         6'd20: code = 8'h12;  6'd21: code = 8'h58;  6'd22: code = 8'h13;  6'd23: code = 8'h14;
         6'd24: code = 8'h15;  6'd25: code = 8'h16;  6'd26: code = 8'h17;  6'd27: code = 8'h18;
         6'd28: code = 8'h19;  6'd29: code = 8'h1a;  6'd30: code = 8'h1b;  6'd31: code = 8'h1c;
         6'd32: code = 8'h61;  6'd33: code = 8'h1d;  6'd34: code = 8'h1e;  6'd35: code = 8'h1f;
         6'd36: code = 8'h80;  6'd37: code = 8'h65;  6'd38: code = 8'h81;  6'd39: code = 8'h82;
         6'd40: code = 8'h83;  6'd41: code = 8'h84;  6'd42: code = 8'h85;  6'd43: code = 8'h86;
         6'd44: code = 8'h87;  6'd45: code = 8'h88;  6'd46: code = 8'h6f;  6'd47: code = 8'h89;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

   // Table for lead 0xD1, trail bytes 0x80..0x8F.
   function automatic logic [7:0] tab_d1(input logic [3:0] idx);
      logic [7:0] code;
      case (idx)
         4'd0:  code = 8'h70;  4'd1:  code = 8'h8a;  4'd2:  code = 8'h8b;  4'd3:  code = 8'h79;
         4'd4:  code = 8'h8d;  4'd5:  code = 8'h78;  4'd6:  code = 8'h8e;  4'd7:  code = 8'h8f;
         4'd8:  code = 8'h90;  4'd9:  code = 8'h91;  4'd10: code = 8'h92;  4'd11: code = 8'h93;
         4'd12: code = 8'h94;  4'd13: code = 8'h95;  4'd14: code = 8'h96;  4'd15: code = 8'h97;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

// ===== sv/u8cy_decode.sv =====
// Byte decoder: maps one UTF-8 byte and the held lead state to zero, one or two display words.
`timescale 1ns / 1ps

module u8cy_decode
   import u8cy_pkg::*;
(
   input  logic [7:0]  in_byte,
   input  logic        in_eos,
   input  logic        lead_held,
   input  logic        lead_is_d1,
   output decode_type  dec
);

   logic [7:0] d0_off;
   logic       hit;
   logic [7:0] hit_code;
   logic       is_lead;
   logic       hold_new;

   assign d0_off  = in_byte - D0_TAB_LO;
   assign is_lead = (in_byte == LEAD_D0) || (in_byte == LEAD_D1);
   assign hold_new = is_lead && !in_eos;

   // Trail byte match against the held lead.
   always_comb begin
      hit      = 1'b0;
      hit_code = 8'h00;
      if (!lead_is_d1) begin
         if (in_byte inside {[D0_TAB_LO:D0_TAB_HI]}) begin
            hit      = 1'b1;
            hit_code = tab_d0(d0_off[5:0]);
         end else if (in_byte == D0_IO_TRAIL) begin
            hit      = 1'b1;
            hit_code = CODE_IO_UP;
         end
      end else begin
         if (in_byte inside {[D1_TAB_LO:D1_TAB_HI]}) begin
            hit      = 1'b1;
            hit_code = tab_d1(in_byte[3:0]);
         end else if (in_byte == D1_IO_TRAIL) begin
            hit      = 1'b1;
            hit_code = CODE_IO_LOW;
         end
      end
   end

   always_comb begin
      dec                = '0;
      dec.word1          = '{code: in_byte, last: in_eos};
      dec.lead_held_nxt  = hold_new;
      dec.lead_is_d1_nxt = hold_new && (in_byte == LEAD_D1);
      if (lead_held && hit) begin
         // Complete two-byte character.
         dec.word_cnt       = 2'd1;
         dec.word0          = '{code: hit_code, last: in_eos};
         dec.lead_held_nxt  = 1'b0;
         dec.lead_is_d1_nxt = 1'b0;
      end else if (lead_held) begin
         // Unmatched pair: the held lead goes out first, then this byte is handled anew.
         dec.word0    = '{code: (lead_is_d1 ? LEAD_D1 : LEAD_D0), last: 1'b0};
         dec.word_cnt = hold_new ? 2'd1 : 2'd2;
      end else begin
         dec.word0    = '{code: in_byte, last: in_eos};
         dec.word_cnt = hold_new ? 2'd0 : 2'd1;
      end
   end

endmodule

// ===== sv/u8cy_outq.sv =====
// Small output queue that takes up to two display words per cycle and delivers one while out_ready is high.
`timescale 1ns / 1ps

module u8cy_outq
   import u8cy_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [1:0]    push_cnt,
   input  disp_word_type push_word0,
   input  disp_word_type push_word1,
   output logic          room2,
   output logic          out_valid,
   input  logic          out_ready,
   output disp_word_type out_word
);

   disp_word_type            entry_ff [QDEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]        count_ff, count_in;
   logic [QPTR_W-1:0]        wr_ptr_p1;
   logic                     pop;

   assign wr_ptr_p1 = wr_ptr_ff + QPTR_W'(1);
   assign out_valid = (count_ff != '0);
   assign out_word  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign room2     = (count_ff <= QCNT_W'(QDEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push_cnt);
   assign rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
   assign count_in  = count_ff + QCNT_W'(push_cnt) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_word0;
      end
      if (push_cnt == 2'd2) begin
         entry_ff[wr_ptr_p1] <= push_word1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("output queue count exceeds depth");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |-> room2)
      else $error("push into output queue without room for two words");

   a_fill_tracks_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff != QCNT_W'(QDEPTH)) |-> (count_ff[QPTR_W-1:0] == QPTR_W'(wr_ptr_ff - rd_ptr_ff)))
      else $error("output queue count disagrees with pointers");

endmodule

// ===== sv/utf8_cyrillic_to_display_code.sv =====
// Top level of the UTF-8 Cyrillic to one-byte display code translator.
`timescale 1ns / 1ps

// This block reads a UTF-8 text stream one byte per word on the req_ side and writes the
// display's one-byte character codes on the rsp_ side. A lead byte 0xD0 or 0xD1 is held until
// the next byte; D0 90..BF and D1 80..8F map through the Cyrillic tables, D0 81 gives 0xCB and
// D1 91 gives 0xEB, and any other pair passes the held lead through unchanged before the
// current byte is handled as a fresh byte. Every other byte passes through unchanged. req_tlast
// marks the final byte of a string; a lead byte held at that point is flushed, and rsp_tlast is
// set on the final code of the string. A byte is registered in the input stage on acceptance
// and decoded from there into a four-word output queue. One byte is accepted per cycle as long
// as the queue has room for two words. A byte that breaks an unmatched pair yields two words,
// but a lead byte that yielded no word always comes before it, so the words never outrun the
// bytes. With rsp_tready held high the queue never holds more than two words after a push and
// req_tready stays high, so bytes are taken back to back. Only a receiver that stalls fills the
// queue and drops req_tready.

module utf8_cyrillic_to_display_code
   import u8cy_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // end_of_string
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_code
   output logic       rsp_tlast    // last
);

   // Input register stage.
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_eos_ff;

   // Lead byte state.
   logic       lead_held_ff, lead_held_in;
   logic       lead_is_d1_ff, lead_is_d1_in;

   decode_type    dec;
   disp_word_type out_word;
   logic          room2;
   logic          s1_fire;
   logic          req_fire;
   logic [1:0]    push_cnt;

   assign s1_fire    = s1_valid_ff && room2;
   assign req_tready = !s1_valid_ff || room2;
   assign req_fire   = req_tvalid && req_tready;
   assign push_cnt   = s1_fire ? dec.word_cnt : 2'd0;

   assign s1_valid_in   = req_fire || (s1_valid_ff && !s1_fire);
   assign lead_held_in  = s1_fire ? dec.lead_held_nxt  : lead_held_ff;
   assign lead_is_d1_in = s1_fire ? dec.lead_is_d1_nxt : lead_is_d1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         lead_held_ff  <= 1'b0;
         lead_is_d1_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         lead_held_ff  <= lead_held_in;
         lead_is_d1_ff <= lead_is_d1_in;
      end
   end

   // Payload of the input stage loads whenever a new word is accepted.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_tdata;
         s1_eos_ff  <= req_tlast;
      end
   end

   u8cy_decode u_decode (
      .in_byte    (s1_byte_ff),
      .in_eos     (s1_eos_ff),
      .lead_held  (lead_held_ff),
      .lead_is_d1 (lead_is_d1_ff),
      .dec        (dec)
   );

   u8cy_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_cnt   (push_cnt),
      .push_word0 (dec.word0),
      .push_word1 (dec.word1),
      .room2      (room2),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_word   (out_word)
   );

   assign rsp_tdata = out_word.code;
   assign rsp_tlast = out_word.last;

   // The end of a string always leaves nothing held.
   a_eos_clears_lead: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_eos_ff) |=> !lead_held_ff)
      else $error("lead byte still held after end of string");

   // The D1 flag only has meaning while a lead is held.
   a_d1_implies_held: assert property (@(posedge clock) disable iff (reset)
      lead_is_d1_ff |-> lead_held_ff)
      else $error("lead_is_d1 set with no lead held");

   // A byte that stays in the input stage is not overwritten.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !room2) |=> (s1_valid_ff && $stable(s1_byte_ff) && $stable(s1_eos_ff)))
      else $error("stalled input stage lost its byte");

   // Holding a new lead produces no word for it in the same step.
   a_hold_one_word_max: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && dec.lead_held_nxt) |-> (dec.word_cnt != 2'd2))
      else $error("new lead held while two words were produced");

endmodule

// ===== test/tb_utf8_cyrillic_to_display_code.sv =====
// Self-checking testbench for the UTF-8 Cyrillic to display code translator.
`timescale 1ns / 1ps

// The bench drives UTF-8 bytes on the req_ stream and checks every display code word that
// leaves on the rsp_ stream. A short directed table comes first. It covers the byte extremes,
// both lead bytes, the ends of both Cyrillic tables, the two single-code trail bytes, a lead
// flushed at the end of a string, and unmatched pairs that give two words for one byte.
// Random strings follow in four phases with different idle and stall rates. Most of their
// tokens are well-formed Cyrillic characters or plain ASCII, and the rest are noise and broken
// pairs. A behavioral translator kept in this file predicts each word. The bench compares every
// word that arrives with the oldest prediction, field by field.

module tb_utf8_cyrillic_to_display_code;
   import u8cy_pkg::*;

   localparam int ITEMS_PER_PHASE = 275;
   localparam int LONG_HOLD       = 80;   // cycles the receiver refuses words in one stretch
   localparam int TAIL_CYCLES     = 10;   // extra cycles run after every predicted word has been accepted

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;   // [7:0] in_byte
   logic       req_tlast;   // end_of_string
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;   // [7:0] out_code
   logic       rsp_tlast;   // last

   utf8_cyrillic_to_display_code DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // One row of the directed table. When typed is set, cnt words w0 and w1 are the expected
   // output. Otherwise the translator below supplies the expected output.
   typedef struct packed {
      logic [7:0]    data;
      logic          eos;
      logic          typed;
      logic [1:0]    cnt;
      disp_word_type w0;
      disp_word_type w1;
   } step_row_type;

   localparam int DIRECTED_ROWS = 26;
   localparam disp_word_type NO_WORD = '{code: 8'h00, last: 1'b0};

   // Cyrillic code tables that the translator uses, indexed from the low end of each
   // trail-byte range.
   logic [7:0] cyr_d0 [48];
   logic [7:0] cyr_d1 [16];

   // Translator state and the words it expects, oldest first.
   logic          held_lead;
   logic          held_is_d1;
   disp_word_type pending_codes [$];

   int errors;
   int stall_pct;      // receiver stall rate for the current phase, in percent
   int holds_asked;    // the stimulus bumps this to ask the receiver for a long hold-off
   int holds_seen;
   int hold_left;
   int bytes_sent;

   step_row_type directed [DIRECTED_ROWS];

   initial begin
      cyr_d0 = '{8'h41, 8'h08, 8'h42, 8'h09, 8'h0a, 8'h45, 8'h0b, 8'h0c,
                 8'h0d, 8'h0e, 8'h4b, 8'h0f, 8'h4d, 8'h48, 8'h4f, 8'h10,
                 8'h50, 8'h43, 8'h54, 8'h11, 8'h12, 8'h58, 8'h13, 8'h14,
                 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a, 8'h1b, 8'h1c,
                 8'h61, 8'h1d, 8'h1e, 8'h1f, 8'h80, 8'h65, 8'h81, 8'h82,
                 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h6f, 8'h89};
      cyr_d1 = '{8'h70, 8'h8a, 8'h8b, 8'h79, 8'h8d, 8'h78, 8'h8e, 8'h8f,
                 8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97};
   end

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Translate one accepted byte. This updates the held-lead state and, if enqueue is set,
   // queues the words that the byte produces.
   function automatic void translate_byte(input logic [7:0] b, input logic eos,
                                          input logic enqueue);
      disp_word_type w;
      logic          hit;
      logic [7:0]    code;
      hit  = 1'b0;
      code = 8'h00;
      if (held_lead) begin
         if (!held_is_d1) begin
            if (b >= D0_TAB_LO && b <= D0_TAB_HI) begin
               code = cyr_d0[b - D0_TAB_LO];
               hit  = 1'b1;
            end else if (b == D0_IO_TRAIL) begin
               code = CODE_IO_UP;
               hit  = 1'b1;
            end
         end else begin
            if (b >= D1_TAB_LO && b <= D1_TAB_HI) begin
               code = cyr_d1[b - D1_TAB_LO];
               hit  = 1'b1;
            end else if (b == D1_IO_TRAIL) begin
               code = CODE_IO_LOW;
               hit  = 1'b1;
            end
         end
         held_lead = 1'b0;
         if (hit) begin
            w.code = code;
            w.last = eos;
            if (enqueue) pending_codes.push_back(w);
            held_is_d1 = 1'b0;
            return;
         end
         // The pair does not match, so the lead goes out on its own and the byte starts over.
         w.code = held_is_d1 ? LEAD_D1 : LEAD_D0;
         w.last = 1'b0;
         if (enqueue) pending_codes.push_back(w);
         held_is_d1 = 1'b0;
      end
      if ((b == LEAD_D0 || b == LEAD_D1) && !eos) begin
         held_lead  = 1'b1;
         held_is_d1 = (b == LEAD_D1);
         return;
      end
      w.code = b;
      w.last = eos;
      if (enqueue) pending_codes.push_back(w);
   endfunction

   // Offer one byte after a random gap and wait for its handshake. A typed row queues its own
   // words, but the translator still follows it so that its state stays in step.
   task automatic offer_byte(input logic [7:0] b, input logic eos, input int idle_pct,
                             input logic typed, input logic [1:0] cnt,
                             input disp_word_type w0, input disp_word_type w1);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = b;
      req_tlast  = eos;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      translate_byte(b, eos, !typed);
      if (typed && cnt > 0) pending_codes.push_back(w0);
      if (typed && cnt > 1) pending_codes.push_back(w1);
      bytes_sent++;
   endtask

   // Build one random string out of tokens and send it, with end_of_string on its last byte.
   // Most tokens are valid two-byte Cyrillic characters or plain ASCII. The rest are noise
   // bytes, broken pairs and lone leads.
   task automatic offer_string(input int idle_pct);
      logic [7:0] bytes [$];
      int         len;
      int         pick;
      len = $urandom_range(1, 12);
      while (bytes.size() < len) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            bytes.push_back(8'($urandom_range(0, 8'h7F)));
         end else if (pick < 55) begin
            bytes.push_back(LEAD_D0);
            bytes.push_back(8'($urandom_range(D0_TAB_LO, D0_TAB_HI)));
         end else if (pick < 62) begin
            bytes.push_back(LEAD_D0);
            bytes.push_back(D0_IO_TRAIL);
         end else if (pick < 77) begin
            bytes.push_back(LEAD_D1);
            bytes.push_back(8'($urandom_range(D1_TAB_LO, D1_TAB_HI)));
         end else if (pick < 83) begin
            bytes.push_back(LEAD_D1);
            bytes.push_back(D1_IO_TRAIL);
         end else if (pick < 91) begin
            bytes.push_back(8'($urandom_range(0, 255)));
         end else if (pick < 97) begin
            bytes.push_back($urandom_range(0, 1) ? LEAD_D1 : LEAD_D0);
            bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            bytes.push_back($urandom_range(0, 1) ? LEAD_D1 : LEAD_D0);
         end
      end
      foreach (bytes[i])
         offer_byte(bytes[i], i == bytes.size() - 1, idle_pct, 1'b0, 2'd0, NO_WORD, NO_WORD);
   endtask

   // Receiver. It stalls at the phase rate. A long hold-off runs out in this process, counted
   // in cycles, while the sender keeps offering bytes.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready = 1'b0;
      end else begin
         if (holds_seen != holds_asked) begin
            holds_seen = holds_asked;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_tready = 1'b0;
            hold_left--;
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Check each accepted word against the oldest prediction.
   always @(posedge clock) begin
      disp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_codes.size() == 0) begin
            $display("%0t: unexpected word code=%02h last=%0b", $time, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = pending_codes.pop_front();
            if (rsp_tdata !== want.code) begin
               $display("%0t: out_code expected %02h actual %02h", $time, want.code, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // Wait until every predicted word has been accepted.
   task automatic wait_drained();
      while (pending_codes.size() != 0) @(posedge clock);
   endtask

   initial begin
      int send_pct [4];
      int stall_by_phase [4];
      int phase_start;
      bit drain_done;
      send_pct       = '{0, 75, 0, 13};
      stall_by_phase = '{0, 0, 75, 13};

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      held_lead   = 1'b0;
      held_is_d1  = 1'b0;
      errors      = 0;
      stall_pct   = 0;
      holds_asked = 0;
      holds_seen  = 0;
      hold_left   = 0;
      bytes_sent  = 0;
      drain_done  = 1'b0;

      // Directed rows. A lead byte that is not at the end of a string gives no word.
      directed = '{
         '{8'h00,       1'b0, 1'b1, 2'd1, '{8'h00, 1'b0},        NO_WORD},
         '{8'hFF,       1'b1, 1'b1, 2'd1, '{8'hFF, 1'b1},        NO_WORD},
         '{LEAD_D0,     1'b0, 1'b1, 2'd0, NO_WORD,               NO_WORD},
         '{D0_TAB_LO,   1'b0, 1'b1, 2'd1, '{8'h41, 1'b0},        NO_WORD},
         '{LEAD_D0,     1'b0, 1'b1, 2'd0, NO_WORD,               NO_WORD},
         '{D0_TAB_HI,   1'b1, 1'b1, 2'd1, '{8'h89, 1'b1},        NO_WORD},
         '{LEAD_D1,     1'b0, 1'b1, 2'd0, NO_WORD,               NO_WORD},
         '{D1_TAB_LO,   1'b0, 1'b1, 2'd1, '{8'h70, 1'b0},        NO_WORD},
         '{LEAD_D1,     1'b0, 1'b1, 2'd0, NO_WORD,               NO_WORD},
         '{D1_TAB_HI,   1'b0, 1'b1, 2'd1, '{8'h97, 1'b0},        NO_WORD},
         '{LEAD_D0,     1'b0, 1'b1, 2'd0, NO_WORD,               NO_WORD},
         '{D0_IO_TRAIL, 1'b0, 1'b1, 2'd1, '{CODE_IO_UP, 1'b0},   NO_WORD},
         '{LEAD_D1,     1'b0, 1'b1, 2'd0, NO_WORD,               NO_WORD},
         '{D1_IO_TRAIL, 1'b1, 1'b1, 2'd1, '{CODE_IO_LOW, 1'b1},  NO_WORD},
         // A lead at the end of a string is flushed as is.
         '{LEAD_D0,     1'b1, 1'b1, 2'd1, '{LEAD_D0, 1'b1},      NO_WORD},
         // Unmatched pairs: the held lead goes out first, then the byte is handled afresh.
         '{LEAD_D1,     1'b0, 1'b1, 2'd0, NO_WORD,               NO_WORD},
         '{8'h41,       1'b0, 1'b1, 2'd2, '{LEAD_D1, 1'b0},      '{8'h41, 1'b0}},
         '{LEAD_D0,     1'b0, 1'b1, 2'd0, NO_WORD,               NO_WORD},
         '{LEAD_D1,     1'b0, 1'b1, 2'd1, '{LEAD_D0, 1'b0},      NO_WORD},
         '{LEAD_D0,     1'b1, 1'b1, 2'd2, '{LEAD_D1, 1'b0},      '{LEAD_D0, 1'b1}},
         // A trail from the other lead's range does not match.
         '{LEAD_D0,     1'b0, 1'b0, 2'd0, NO_WORD,               NO_WORD},
         '{D1_TAB_HI,   1'b0, 1'b0, 2'd0, NO_WORD,               NO_WORD},
         '{LEAD_D1,     1'b0, 1'b0, 2'd0, NO_WORD,               NO_WORD},
         '{8'hA5,       1'b1, 1'b0, 2'd0, NO_WORD,               NO_WORD},
         // A zero byte is an ordinary byte, and only end_of_string ends the string.
         '{LEAD_D1,     1'b0, 1'b1, 2'd0, NO_WORD,               NO_WORD},
         '{8'h00,       1'b1, 1'b1, 2'd2, '{LEAD_D1, 1'b0},      '{8'h00, 1'b1}}
      };

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         offer_byte(directed[i].data, directed[i].eos, 0, directed[i].typed,
                    directed[i].cnt, directed[i].w0, directed[i].w1);

      // Random phases. In the first one the receiver holds off for a long stretch while the
      // sender keeps offering bytes, so the output queue fills and req_tready drops. In the
      // second one the sender stops once until every predicted word has come back.
      for (int p = 0; p < 4; p++) begin
         stall_pct   = stall_by_phase[p];
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < ITEMS_PER_PHASE) begin
            if (p == 0 && bytes_sent - phase_start >= 100 && holds_asked == 0)
               holds_asked++;
            if (p == 1 && bytes_sent - phase_start >= 100 && !drain_done) begin
               @(negedge clock);
               req_tvalid = 1'b0;
               wait_drained();
               drain_done = 1'b1;
            end
            offer_string(send_pct[p]);
         end
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      stall_pct  = 0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // The slowest correct run takes well under a tenth of this time.
   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
